// ===== rtl/two_link_inverse_kinematics_unit_assert.svh =====
// Assertion macros for the two-link inverse kinematics unit.
// Used by two_link_inverse_kinematics_unit.sv; no other dependencies.
`ifndef TWO_LINK_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLIK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlik assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlik assertion failed");

`endif

// ===== rtl/tlik_pkg.sv =====
// Shared constants, types and helper functions of the two-link inverse kinematics unit.
// Used by tlik_vector and two_link_inverse_kinematics_unit; depends on nothing.
package tlik_pkg;

	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 12;

	localparam int ANG_W = FRACTION_BITS + 4;  // internal angle, range below +-8 rad
	localparam int SUM_W = ANG_W + 1;          // shoulder sum and difference
	localparam int VEC_W = 50;                 // vector unit input
	localparam int CW    = 45;                 // CORDIC datapath after normalizing

	localparam int NORM_TOP    = 41;           // magnitude lands in [2^40, 2^41)
	localparam int NORM_RIGHT  = 4;            // right shifts by 8, 4, 2, 1
	localparam int NORM_STAGES = 10;           // then left shifts by 32 .. 1

	localparam int SQRT_STAGES = 31;           // one root bit per stage, 62-bit radicand

	localparam int VEC_LAT  = 1 + NORM_STAGES + CORDIC_STEPS + 1;
	localparam int PIPE_LAT = 4 + SQRT_STAGES + 2 + VEC_LAT + 2;

	localparam int Q30_SH  = 30 - FRACTION_BITS;
	localparam longint Q30_RND = longint'(1) << (Q30_SH - 1);

	localparam int OUT_SHR = (FRACTION_BITS > 12) ? FRACTION_BITS - 12 : 0;
	localparam int OUT_SHL = (FRACTION_BITS < 12) ? 12 - FRACTION_BITS : 0;
	localparam int OUT_RND = (2 ** OUT_SHR) / 2;

	localparam longint ATAN_Q30 [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};
	localparam longint PI_Q30 = 64'd3373259426;

	localparam logic signed [ANG_W-1:0] PI_F = ANG_W'((PI_Q30 + Q30_RND) >>> Q30_SH);

	// Solution count codes.
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] REG_UPPER = 1'b0;
	localparam logic [0:0] REG_LOWER = 1'b1;

	typedef struct packed {
		logic [1:0] cnt;
		logic       pos;  // single solution with the arm stretched out
	} cls_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        l1;
		logic [14:0]        l2;
		logic signed [33:0] n;
		logic [31:0]        d;
		cls_t               cls;
	} carry_t;

	function automatic logic signed [ANG_W-1:0] atan_f(input int i);
		return ANG_W'((ATAN_Q30[i] + Q30_RND) >>> Q30_SH);
	endfunction

	function automatic int norm_shift(input int j);
		return (j < NORM_RIGHT) ? (8 >> j) : (32 >> (j - NORM_RIGHT));
	endfunction

	// Round to 12 fraction bits and saturate to 16 bit signed.
	function automatic logic [15:0] to_out(input logic signed [SUM_W-1:0] a);
		logic signed [SUM_W+12:0] w;
		w = (SUM_W + 13)'(a);
		w = w + (SUM_W + 13)'(OUT_RND);
		w = w >>> OUT_SHR;
		w = w <<< OUT_SHL;
		if (w > (SUM_W + 13)'(32767))
			return 16'h7fff;
		else if (w < -(SUM_W + 13)'(32768))
			return 16'h8000;
		return w[15:0];
	endfunction

endpackage

// ===== rtl/tlik_vector.sv =====
// Pipelined vectoring unit: atan2(vy, vx) by fold, normalize and CORDIC stages.
// Depends on tlik_pkg for widths, the arctangent table and the stage counts.
module tlik_vector import tlik_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VEC_W-1:0] vy,
	input  logic signed [VEC_W-1:0] vx,
	output logic signed [ANG_W-1:0] angle
);

	localparam int CARRY_N = NORM_STAGES + CORDIC_STEPS;

	logic signed [VEC_W-1:0] nx_s [0:NORM_STAGES];
	logic signed [VEC_W-1:0] ny_s [0:NORM_STAGES];
	logic [VEC_W-1:0]        nm_s [0:NORM_STAGES];
	logic signed [ANG_W-1:0] off_s [0:CARRY_N];
	logic                    zero_s [0:CARRY_N];
	logic signed [CW-1:0]    cx_s [1:CORDIC_STEPS];
	logic signed [CW-1:0]    cy_s [1:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cz_s [1:CORDIC_STEPS];

	logic                    neg;
	logic signed [VEC_W-1:0] fx, fy;
	logic [VEC_W-1:0]        ay, m0;

	// Fold the left half plane onto the right one.
	always_comb begin
		neg = vx[VEC_W-1];
		fx  = neg ? -vx : vx;
		fy  = neg ? -vy : vy;
		ay  = fy[VEC_W-1] ? VEC_W'(-fy) : VEC_W'(fy);
		m0  = (VEC_W'(fx) > ay) ? VEC_W'(fx) : ay;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s[0]   <= fx;
			ny_s[0]   <= fy;
			nm_s[0]   <= m0;
			zero_s[0] <= (vx == '0) && (vy == '0);
			if (!neg)
				off_s[0] <= '0;
			else if (vy[VEC_W-1])
				off_s[0] <= -PI_F;
			else
				off_s[0] <= PI_F;
		end
	end

	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int K = norm_shift(j);
		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j+1] <= nx_s[j];
				ny_s[j+1] <= ny_s[j];
				nm_s[j+1] <= nm_s[j];
				if (j < NORM_RIGHT) begin
					if (nm_s[j] >= (VEC_W'(1) << (NORM_TOP - 1 + K))) begin
						nx_s[j+1] <= nx_s[j] >>> K;
						ny_s[j+1] <= ny_s[j] >>> K;
						nm_s[j+1] <= nm_s[j] >> K;
					end
				end else begin
					if (nm_s[j] < (VEC_W'(1) << (NORM_TOP - K))) begin
						nx_s[j+1] <= nx_s[j] <<< K;
						ny_s[j+1] <= ny_s[j] <<< K;
						nm_s[j+1] <= nm_s[j] << K;
					end
				end
				off_s[j+1]  <= off_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [ANG_W-1:0] T = atan_f(i);
		logic signed [CW-1:0]    xi, yi;
		logic signed [ANG_W-1:0] zi;
		if (i == 0) begin : g_first
			assign xi = nx_s[NORM_STAGES][CW-1:0];
			assign yi = ny_s[NORM_STAGES][CW-1:0];
			assign zi = '0;
		end else begin : g_next
			assign xi = cx_s[i];
			assign yi = cy_s[i];
			assign zi = cz_s[i];
		end
		// Rotate toward the x axis.
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi[CW-1]) begin
					cx_s[i+1] <= xi - (yi >>> i);
					cy_s[i+1] <= yi + (xi >>> i);
					cz_s[i+1] <= zi - T;
				end else begin
					cx_s[i+1] <= xi + (yi >>> i);
					cy_s[i+1] <= yi - (xi >>> i);
					cz_s[i+1] <= zi + T;
				end
				off_s[NORM_STAGES+i+1]  <= off_s[NORM_STAGES+i];
				zero_s[NORM_STAGES+i+1] <= zero_s[NORM_STAGES+i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= zero_s[CARRY_N] ? '0 : cz_s[CORDIC_STEPS] + off_s[CARRY_N];
	end

endmodule

// ===== rtl/two_link_inverse_kinematics_unit.sv =====
// Top level of the two-link planar arm inverse kinematics unit.
// Depends on tlik_pkg, tlik_vector and two_link_inverse_kinematics_unit_assert.svh.

// Inverse kinematics for a two-link planar arm. Each slave transaction carries a
// target point (x, y) in signed Q8.8; each master transaction carries the
// solution count and two (shoulder, elbow) angle pairs in signed Q4.12 radians,
// one result per target, in order. The link lengths come from the write port
// (index 0 upper link, index 1 lower link, unsigned Q7.8, both reset to 256) and
// may be written only while the pipeline is empty. The block is one fully
// pipelined datapath: it takes a new target in every cycle while no result waits
// at the output. Its stages in series are four for the squares, classification and
// radicand, 31 for the square root (one root bit a stage), two for the
// second-arctangent operands, 28 for the three parallel vectoring units (fold,
// ten normalize shifts, 16 CORDIC steps one a stage, final offset), one to form the
// shoulder sum and difference and one for rounding into the output register.
// The whole pipeline holds while a result waits and m_tready is low, so s_tready
// follows m_tready whenever the output register is full.
module two_link_inverse_kinematics_unit import tlik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// target_x [15:0], target_y [31:16]
	input  logic [31:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// solution_count [1:0], first_shoulder [17:2], first_elbow [33:18],
	// second_shoulder [49:34], second_elbow [65:50], zero fill [71:66]
	output logic [71:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	logic adv;
	logic [PIPE_LAT-1:0] vld_q;
	logic [14:0] l1_q, l2_q;

	// Advance every stage together unless a result waits at the output.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	// Link length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 15'd256;
			l2_q <= 15'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPPER: l1_q <= cfg_data;
				REG_LOWER: l2_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Stage 1: squares and the link product.
	logic signed [15:0] tx, ty;
	logic signed [31:0] tx32, ty32;
	logic signed [15:0] x_s1, y_s1;
	logic [14:0] l1_s1, l2_s1;
	logic [31:0] xx_s1, yy_s1;
	logic [29:0] l11_s1, l22_s1, l12_s1;

	assign tx   = s_tdata[15:0];
	assign ty   = s_tdata[31:16];
	assign tx32 = 32'(tx);
	assign ty32 = 32'(ty);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= tx;
			y_s1   <= ty;
			l1_s1  <= l1_q;
			l2_s1  <= l2_q;
			xx_s1  <= 32'(tx32 * tx32);
			yy_s1  <= 32'(ty32 * ty32);
			l11_s1 <= 30'(l1_q) * 30'(l1_q);
			l22_s1 <= 30'(l2_q) * 30'(l2_q);
			l12_s1 <= 30'(l1_q) * 30'(l2_q);
		end
	end

	// Stage 2: numerator and denominator of the elbow cosine.
	logic signed [15:0] x_s2, y_s2;
	logic [14:0] l1_s2, l2_s2;
	logic signed [33:0] n_s2;
	logic [31:0] d_s2;
	logic dz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			l1_s2 <= l1_s1;
			l2_s2 <= l2_s1;
			n_s2  <= $signed({2'b00, xx_s1}) + $signed({2'b00, yy_s1})
				- $signed({4'b0000, l11_s1}) - $signed({4'b0000, l22_s1});
			d_s2  <= {1'b0, l12_s1, 1'b0};
			dz_s2 <= (l12_s1 == '0);
		end
	end

	// Stage 3: classify the point, square D and N.
	logic signed [33:0] d_ext;
	logic [33:0] n_abs;
	cls_t cls_c;
	carry_t c_s3;
	logic [63:0] dd_s3, nn_s3;

	always_comb begin
		d_ext = $signed({2'b00, d_s2});
		n_abs = n_s2[33] ? 34'(-n_s2) : 34'(n_s2);
		cls_c.pos = (n_s2 == d_ext);
		if (dz_s2 || (n_s2 > d_ext) || (n_s2 < -d_ext))
			cls_c.cnt = CNT_NONE;
		else if ((n_s2 == d_ext) || (n_s2 == -d_ext))
			cls_c.cnt = CNT_ONE;
		else
			cls_c.cnt = CNT_TWO;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3.x   <= x_s2;
			c_s3.y   <= y_s2;
			c_s3.l1  <= l1_s2;
			c_s3.l2  <= l2_s2;
			c_s3.n   <= n_s2;
			c_s3.d   <= d_s2;
			c_s3.cls <= cls_c;
			dd_s3    <= 64'(d_s2) * 64'(d_s2);
			nn_s3    <= 64'(n_abs[31:0]) * 64'(n_abs[31:0]);
		end
	end

	// Stage 4 and the square root: one result bit a stage.
	logic [61:0] sq_v_s [0:SQRT_STAGES];
	logic [62:0] sq_r_s [0:SQRT_STAGES];
	carry_t      sq_c_s [0:SQRT_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_v_s[0] <= 62'(dd_s3 - nn_s3);
			sq_r_s[0] <= '0;
			sq_c_s[0] <= c_s3;
		end
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STAGES - 1 - k));
		logic [62:0] trial;
		assign trial = sq_r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_c_s[k+1] <= sq_c_s[k];
				if ({1'b0, sq_v_s[k]} >= trial) begin
					sq_v_s[k+1] <= 62'({1'b0, sq_v_s[k]} - trial);
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + BIT;
				end else begin
					sq_v_s[k+1] <= sq_v_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
			end
		end
	end

	// Stage 5: products for the second arctangent.
	logic [30:0] root;
	carry_t c_s5, c_s6;
	logic [30:0] s_s5, s_s6;
	logic [45:0] l2s_s5, phy_s6;
	logic [46:0] l1d_s5;
	logic signed [48:0] l2n_s5;
	logic signed [49:0] phx_s6;

	assign root = sq_r_s[SQRT_STAGES][30:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5   <= sq_c_s[SQRT_STAGES];
			s_s5   <= root;
			l2s_s5 <= 46'(sq_c_s[SQRT_STAGES].l2) * 46'(root);
			l1d_s5 <= 47'(sq_c_s[SQRT_STAGES].l1) * 47'(sq_c_s[SQRT_STAGES].d);
			l2n_s5 <= $signed({34'b0, sq_c_s[SQRT_STAGES].l2})
				* 49'(sq_c_s[SQRT_STAGES].n);
		end
	end

	// Stage 6: operand sum of the second arctangent.
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s6   <= c_s5;
			s_s6   <= s_s5;
			phy_s6 <= l2s_s5;
			phx_s6 <= $signed({3'b000, l1d_s5}) + 50'(l2n_s5);
		end
	end

	// Three vectoring units in parallel.
	logic signed [ANG_W-1:0] base_a, q2_a, phi_a;

	tlik_vector u_base (
		.clk   (clk),
		.en    (adv),
		.vy    (VEC_W'(c_s6.y)),
		.vx    (VEC_W'(c_s6.x)),
		.angle (base_a)
	);

	tlik_vector u_elbow (
		.clk   (clk),
		.en    (adv),
		.vy    ($signed({19'b0, s_s6})),
		.vx    (VEC_W'(c_s6.n)),
		.angle (q2_a)
	);

	tlik_vector u_phi (
		.clk   (clk),
		.en    (adv),
		.vy    ($signed({4'b0000, phy_s6})),
		.vx    (phx_s6),
		.angle (phi_a)
	);

	// Hold the classification alongside the vectoring units.
	cls_t cls_d_s [0:VEC_LAT-1];

	always_ff @(posedge clk) begin
		if (adv)
			cls_d_s[0] <= c_s6.cls;
	end

	for (genvar v = 1; v < VEC_LAT; v++) begin : g_cls
		always_ff @(posedge clk) begin
			if (adv)
				cls_d_s[v] <= cls_d_s[v-1];
		end
	end

	// Stage 7: shoulder angles for both elbow signs.
	cls_t cls_s7;
	logic signed [SUM_W-1:0] base_s7, q2_s7, dif_s7, sum_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s7  <= cls_d_s[VEC_LAT-1];
			base_s7 <= SUM_W'(base_a);
			q2_s7   <= SUM_W'(q2_a);
			dif_s7  <= SUM_W'(base_a) - SUM_W'(phi_a);
			sum_s7  <= SUM_W'(base_a) + SUM_W'(phi_a);
		end
	end

	// Output register: round, saturate, zero the unused fields.
	logic [1:0]  cnt_o;
	logic [15:0] fs_o, fe_o, ss_o, se_o;

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_o <= cls_s7.cnt;
			fs_o  <= '0;
			fe_o  <= '0;
			ss_o  <= '0;
			se_o  <= '0;
			case (cls_s7.cnt)
				CNT_ONE: begin
					fs_o <= to_out(base_s7);
					fe_o <= cls_s7.pos ? 16'd0 : to_out(SUM_W'(PI_F));
				end
				CNT_TWO: begin
					fs_o <= to_out(dif_s7);
					fe_o <= to_out(q2_s7);
					ss_o <= to_out(sum_s7);
					se_o <= to_out(-q2_s7);
				end
				default: ;
			endcase
		end
	end

	assign m_tdata = {6'b000000, se_o, ss_o, fe_o, fs_o, cnt_o};

`include "two_link_inverse_kinematics_unit_assert.svh"

	// An unreachable point reports all angles zero.
	`TLIK_ASSERT_NOW(a_none_zero, clk, arst_n,
		m_tvalid && (m_tdata[1:0] == CNT_NONE), m_tdata[65:2] == '0)
	// A single solution leaves the second pair zero.
	`TLIK_ASSERT_NOW(a_one_second_zero, clk, arst_n,
		m_tvalid && (m_tdata[1:0] == CNT_ONE), m_tdata[65:34] == '0)
	// The count never takes the unused code.
	`TLIK_ASSERT_NOW(a_cnt_legal, clk, arst_n, m_tvalid, m_tdata[1:0] != 2'd3)
	// A waiting result stalls intake and stays valid.
	`TLIK_ASSERT_NEXT(a_stall_hold, clk, arst_n,
		m_tvalid && !m_tready, m_tvalid && !(s_tready && !m_tready))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-link inverse kinematics unit.
// Depends on tlik_pkg and two_link_inverse_kinematics_unit; drives targets, checks solutions.
module testbench import tlik_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = PIPE_LAT + 40;
	localparam int LONG_HOLD      = 400;

	typedef struct packed {
		logic [1:0]  cnt;
		logic [15:0] fs;
		logic [15:0] fe;
		logic [15:0] ss;
		logic [15:0] se;
	} solution_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 fixed;
		solution_t          sol;
	} target_row_t;

	logic        clk;
	logic        arst_n;
	logic [31:0] s_tdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [14:0] cfg_data;

	two_link_inverse_kinematics_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Link lengths as the predictor sees them, updated when a write is sampled.
	longint    upper_len = 256;
	longint    lower_len = 256;
	solution_t pending_solutions[$];
	int        fail_count = 0;
	int        idle_cycles = 0;
	bit        calm = 0;        // no random idling on either side while set
	bit        hold_request = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint q30_to_internal(longint v);
		return (v + (longint'(1) << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
	endfunction

	// Angle of vector (xv, yv) by CORDIC vectoring at internal precision.
	function automatic longint vector_angle(longint yv, longint xv);
		longint off, z, m, xs, ys, t;
		off = 0;
		z = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			off = (yv >= 0) ? q30_to_internal(PI_Q30) : -q30_to_internal(PI_Q30);
			xv = -xv;
			yv = -yv;
		end
		m = (xv < 0 ? -xv : xv);
		if ((yv < 0 ? -yv : yv) > m)
			m = (yv < 0 ? -yv : yv);
		while (m < (longint'(1) << 40)) begin
			xv = xv * 2;
			yv = yv * 2;
			m = m * 2;
		end
		while (m >= (longint'(1) << 41)) begin
			xv = xv >>> 1;
			yv = yv >>> 1;
			m = m >>> 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			t = q30_to_internal(ATAN_Q30[i]);
			if (yv < 0) begin
				xv = xv - ys;
				yv = yv + xs;
				z = z - t;
			end else begin
				xv = xv + ys;
				yv = yv - xs;
				z = z + t;
			end
		end
		return z + off;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Round an internal angle to Q4.12 and saturate to 16 bits.
	function automatic logic [15:0] angle_q12(longint a);
		longint r;
		if (FRACTION_BITS > 12)
			r = (a + (longint'(1) << (FRACTION_BITS - 13))) >>> (FRACTION_BITS - 12);
		else
			r = a * (longint'(1) << (12 - FRACTION_BITS));
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function automatic solution_t solve_target(logic signed [15:0] tx, logic signed [15:0] ty);
		solution_t      sol;
		longint         x, y, n, d, base, q2, phi, s;
		longint unsigned rem;
		sol = '0;
		x = tx;
		y = ty;
		d = 2 * upper_len * lower_len;
		n = x * x + y * y - upper_len * upper_len - lower_len * lower_len;
		if (d == 0 || n > d || n < -d)
			return sol;
		base = vector_angle(y, x);
		if (n == d || n == -d) begin
			sol.cnt = CNT_ONE;
			sol.fs = angle_q12(base);
			sol.fe = (n == d) ? 16'd0 : angle_q12(q30_to_internal(PI_Q30));
			return sol;
		end
		rem = longint'(unsigned'(d)) * longint'(unsigned'(d));
		rem = longint'(unsigned'(d)) * longint'(unsigned'(d)) - longint'(unsigned'(n * n));
		s = floor_root(rem);
		q2 = vector_angle(s, n);
		phi = vector_angle(lower_len * s, upper_len * d + lower_len * n);
		sol.cnt = CNT_TWO;
		sol.fs = angle_q12(base - phi);
		sol.fe = angle_q12(q2);
		sol.ss = angle_q12(base + phi);
		sol.se = angle_q12(-q2);
		return sol;
	endfunction

	// ---------------------------------------------------------------- monitor

	// Sample both handshakes and the write port on the same edge; predict on accept.
	always @(posedge clk) begin
		solution_t got, want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_UPPER)
					upper_len = cfg_data;
				else
					lower_len = cfg_data;
			end
			if (s_tvalid && s_tready)
				pending_solutions.insert(pending_solutions.size(),
					solve_target(s_tdata[15:0], s_tdata[31:16]));
			if (m_tvalid && m_tready) begin
				got = '{cnt: m_tdata[1:0], fs: m_tdata[17:2], fe: m_tdata[33:18],
					ss: m_tdata[49:34], se: m_tdata[65:50]};
				if (pending_solutions.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					want = pending_solutions.pop_front();
					if (got.cnt !== want.cnt || got.fs !== want.fs || got.fe !== want.fe ||
						got.ss !== want.ss || got.se !== want.se) begin
						$display("%0t: mismatch expected cnt=%0d fs=%0d fe=%0d ss=%0d se=%0d",
							$time, want.cnt, $signed(want.fs), $signed(want.fe),
							$signed(want.ss), $signed(want.se));
						$display("%0t:          actual   cnt=%0d fs=%0d fe=%0d ss=%0d se=%0d",
							$time, got.cnt, $signed(got.fs), $signed(got.fe),
							$signed(got.ss), $signed(got.se));
						fail_count++;
					end
				end
			end
		end
	end

	// Fixed expectations from the directed table are checked against the predictor's.
	task automatic check_fixed(target_row_t row);
		solution_t want;
		want = solve_target(row.x, row.y);
		if (want !== row.sol) begin
			$display("%0t: mismatch expected %h actual %h (directed x=%0d y=%0d)",
				$time, row.sol, want, row.x, row.y);
			fail_count++;
		end
	endtask

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- receiver

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// Hold off long enough for the pipeline to fill and stall the input.
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 0;
				m_tready <= 1'b1;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 13);
			end
		end
	end

	// ---------------------------------------------------------------- sender

	task automatic send_target(logic signed [15:0] x, logic signed [15:0] y);
		int gap;
		if (!calm && $urandom_range(99) < 13) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {y, x};
		s_tvalid <= 1'b1;
		// Ready only changes at rising edges, so sampling it at the falling one is safe.
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain_and_idle();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (pending_solutions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [14:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly reachable points: pick a radius inside the annulus and a point on it.
	task automatic random_target(output logic signed [15:0] x, output logic signed [15:0] y);
		longint r_lo, r_hi, r, xv, yv, lim;
		int pick;
		pick = $urandom_range(99);
		r_lo = (upper_len > lower_len) ? upper_len - lower_len : lower_len - upper_len;
		r_hi = upper_len + lower_len;
		if (pick < 20 || r_lo > 46000) begin
			x = $urandom;
			y = $urandom;
			return;
		end
		if (pick < 28)
			r = ($urandom_range(1) != 0) ? r_hi : r_lo;
		else
			r = r_lo + longint'($urandom_range(32'(r_hi > 46000 ? 46000 - r_lo : r_hi - r_lo)));
		lim = (r > 32767) ? 32767 : r;
		if (pick < 28) begin
			xv = (r > 32767) ? 32767 : r;
			yv = floor_root(longint'(r * r - xv * xv));
		end else begin
			xv = longint'($urandom_range(32'(2 * lim))) - lim;
			yv = floor_root(longint'(r * r - xv * xv));
		end
		if (yv > 32767)
			yv = 32767;
		if ($urandom_range(1) != 0)
			xv = -xv;
		if ($urandom_range(1) != 0)
			yv = -yv;
		x = xv[15:0];
		y = yv[15:0];
	endtask

	target_row_t directed_rows[] = '{
		// Origin with equal links: arm folded back, elbow at pi.
		'{16'sd0, 16'sd0, 1'b1, '{CNT_ONE, 16'd0, 16'd12868, 16'd0, 16'd0}},
		// Far corners and the far end of the negative x axis lie beyond reach.
		'{16'sh7fff, 16'sh7fff, 1'b1, '{CNT_NONE, 16'd0, 16'd0, 16'd0, 16'd0}},
		'{-16'sh8000, -16'sh8000, 1'b1, '{CNT_NONE, 16'd0, 16'd0, 16'd0, 16'd0}},
		'{16'sh7fff, -16'sh8000, 1'b1, '{CNT_NONE, 16'd0, 16'd0, 16'd0, 16'd0}},
		'{-16'sh8000, 16'sd0, 1'b1, '{CNT_NONE, 16'd0, 16'd0, 16'd0, 16'd0}},
		// Arm stretched out along each axis.
		'{16'sd512, 16'sd0, 1'b0, '0},
		'{-16'sd512, 16'sd0, 1'b0, '0},
		'{16'sd0, 16'sd512, 1'b0, '0},
		'{16'sd0, -16'sd512, 1'b0, '0},
		// Two solutions in each quadrant and on the axes, and one point just beyond reach.
		'{16'sd256, 16'sd256, 1'b0, '0},
		'{-16'sd256, 16'sd256, 1'b0, '0},
		'{-16'sd256, -16'sd256, 1'b0, '0},
		'{16'sd256, -16'sd256, 1'b0, '0},
		'{-16'sd300, 16'sd0, 1'b0, '0},
		'{16'sd1, 16'sd0, 1'b0, '0},
		'{16'sd0, -16'sd1, 1'b0, '0},
		'{16'sd511, 16'sd1, 1'b0, '0},
		'{16'sd513, 16'sd0, 1'b0, '0},
		'{-16'sd1, -16'sd1, 1'b0, '0}
	};

	// Link settings per phase: reset value, both extremes, mixed, then random.
	int unsigned phase_upper[8] = '{256, 1, 32767, 32767, 1, 100, 0, 0};
	int unsigned phase_lower[8] = '{256, 1, 32767, 1, 32767, 300, 0, 0};

	initial begin
		logic signed [15:0] tx, ty;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_UPPER;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset lengths.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].fixed)
				check_fixed(directed_rows[i]);
			send_target(directed_rows[i].x, directed_rows[i].y);
		end
		drain_and_idle();

		for (int p = 0; p < 8; p++) begin
			if (p >= 6) begin
				phase_upper[p] = $urandom_range(1, 32767);
				phase_lower[p] = $urandom_range(1, 32767);
			end
			write_reg(REG_UPPER, phase_upper[p][14:0]);
			write_reg(REG_LOWER, phase_lower[p][14:0]);
			calm = (p == 2);
			for (int k = 0; k < 50; k++) begin
				if (p == 3 && k == 10)
					hold_request = 1;
				if (p == 5 && k == 25) begin
					// Pause the sender until every outstanding result is back.
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending_solutions.size() != 0)
						@(posedge clk);
				end
				random_target(tx, ty);
				send_target(tx, ty);
			end
			drain_and_idle();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tlik_pkg.sv
rtl/tlik_vector.sv
rtl/two_link_inverse_kinematics_unit.sv
tb/testbench.sv
